>>> design/mbcf_pkg.sv
// Package for the media box chain finder: status codes, register indexes,
// configuration and result structs. No dependencies.
`default_nettype none

package mbcf_pkg;

	localparam int unsigned HEADER_BYTES = 8;
	localparam int unsigned TYPE_BYTES   = 4;

	localparam int unsigned CFG_INDEX_WIDTH = 3;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_CONTAINER_START    = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_CONTAINER_LENGTH   = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_CHILD_START_OFFSET = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_WANTED_TYPE        = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BUFFER_LENGTH      = 3'd4;

	typedef enum logic [1:0] {
		ST_FOUND     = 2'd0,
		ST_NO_ROOM   = 2'd1,
		ST_MALFORMED = 2'd2,
		ST_BAD_START = 2'd3
	} status_t;

	typedef struct packed {
		logic [31:0] container_start;
		logic [31:0] container_length;
		logic [31:0] child_start_offset;
		logic [31:0] wanted_type;
		logic [31:0] buffer_length;
	} cfg_t;

	typedef struct packed {
		logic [31:0] hit_size;
		logic [31:0] box_offset;
		status_t     status;
	} result_t;

endpackage

`default_nettype wire

>>> design/mbcf_walk.sv
// Box chain walker: walk state registers and the per-byte next-state logic.
// Depends on mbcf_pkg for the config and result structs and status codes.
`default_nettype none

module mbcf_walk
	import mbcf_pkg::*;
#(
	parameter int OFFSET_WIDTH = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cfg_t       cfg,
	input  wire logic       item_valid,
	input  wire logic [7:0] data_byte,
	input  wire logic       last,
	input  wire logic       advance,
	output logic            emit,
	output result_t         result
);

	localparam int OW = OFFSET_WIDTH;
	localparam int SW = (OW > 32) ? OW : 32;

	logic [OW-1:0] pos_q, cursor_q;
	logic [55:0]   shift_q;
	logic [3:0]    count_q;
	logic          done_q;

	logic [OW-1:0] pos_n, cursor_n;
	logic [55:0]   shift_n;
	logic [3:0]    count_n;
	logic          done_n;

	logic [OW-1:0] cs, bl, cend, limit, start, cur, endb;
	logic [3:0]    cnt;
	logic [55:0]   shift;
	logic [63:0]   full;
	logic [31:0]   size, typ;
	logic [SW-1:0] sum;
	logic          first, capture, emit_n;

	function automatic logic no_room(input logic [OW-1:0] c, input logic [OW-1:0] lim);
		logic [OW-1:0] nxt;
		nxt = c + OW'(HEADER_BYTES);
		return (nxt < c) || (nxt > lim);
	endfunction

	always_comb begin
		cs    = OW'(cfg.container_start);
		bl    = OW'(cfg.buffer_length);
		cend  = cs + OW'(cfg.container_length);
		if (cend < cs) begin
			cend = bl;
		end
		limit = (cend < bl) ? cend : bl;
		start = cs + OW'(cfg.child_start_offset);

		first = !done_q && (pos_q == '0);
		cur   = first ? start : cursor_q;
		cnt   = first ? 4'd0 : count_q;
		shift = first ? 56'd0 : shift_q;

		emit_n            = 1'b0;
		result.status     = ST_NO_ROOM;
		result.box_offset = 32'd0;
		result.hit_size   = 32'd0;
		done_n            = done_q;
		cursor_n          = cur;
		count_n           = cnt;
		shift_n           = shift;
		full              = {shift, data_byte};
		size              = full[63:32];
		typ               = full[31:0];
		sum               = SW'(cur) + SW'(size);
		endb              = sum[OW-1:0];

		if (first) begin
			if (start < cs) begin
				emit_n        = 1'b1;
				done_n        = 1'b1;
				result.status = ST_BAD_START;
			end else if (no_room(start, limit)) begin
				emit_n        = 1'b1;
				done_n        = 1'b1;
				result.status = ST_NO_ROOM;
			end
		end

		// take the byte only when it sits at the next header position
		capture = !done_n && (cnt < 4'(HEADER_BYTES)) && (pos_q == cur + OW'(cnt));
		if (capture) begin
			shift_n = full[55:0];
			count_n = cnt + 4'd1;
			if (count_n == 4'(HEADER_BYTES)) begin
				if (size < 32'(HEADER_BYTES) || endb < cur || endb > limit) begin
					emit_n        = 1'b1;
					done_n        = 1'b1;
					result.status = ST_MALFORMED;
				end else if (typ == cfg.wanted_type) begin
					emit_n            = 1'b1;
					done_n            = 1'b1;
					result.status     = ST_FOUND;
					result.box_offset = 32'(cur);
					result.hit_size   = size;
				end else begin
					cursor_n = endb;
					count_n  = 4'd0;
					shift_n  = 56'd0;
					if (no_room(endb, limit)) begin
						emit_n        = 1'b1;
						done_n        = 1'b1;
						result.status = ST_NO_ROOM;
					end
				end
			end
		end

		pos_n = (pos_q != '1) ? pos_q + OW'(1) : pos_q;

		if (last) begin
			if (!done_n) begin
				emit_n        = 1'b1;
				result.status = ST_NO_ROOM;
			end
			pos_n    = '0;
			cursor_n = '0;
			shift_n  = 56'd0;
			count_n  = 4'd0;
			done_n   = 1'b0;
		end

		emit = item_valid && emit_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			cursor_q <= '0;
			shift_q  <= 56'd0;
			count_q  <= 4'd0;
			done_q   <= 1'b0;
		end else if (advance) begin
			pos_q    <= pos_n;
			cursor_q <= cursor_n;
			shift_q  <= shift_n;
			count_q  <= count_n;
			done_q   <= done_n;
		end
	end

endmodule

`default_nettype wire

>>> design/media_box_chain_finder.sv
// Top level of the media box chain finder: config registers, input stage,
// result register. Depends on mbcf_pkg and mbcf_walk.
//
// Usage: write the five registers on the cfg channel (index 0..4 in order:
// container start, container length, child start offset, wanted type,
// buffer length) while no buffer is streaming; cfg_ready is always high.
// Then stream the buffer one byte per transfer on the s_ group, from offset
// zero, with s_tlast on the final byte. The block walks the chain of child
// boxes inside the container and sends exactly one result transfer per
// buffer on the m_ group: the first box whose type matches, or a status
// (no room left, malformed box, bad start offset). Bytes after the decision
// are consumed and dropped until s_tlast, which rearms the walk.
// Throughput: one byte per cycle while the result register can take a result;
// the per-byte work is one pass through the walker's compare and add logic
// between the input stage and the result register. A result appears on
// m_tvalid once its deciding byte has passed the input stage into the walker.
// Reset clears the walk state, the registers and both stages. When the
// receiver stalls, the result register holds; bytes that decide nothing keep
// flowing, and a byte that would give a second result waits in the input
// stage until the result register frees.
`default_nettype none

module media_box_chain_finder
	import mbcf_pkg::*;
#(
	parameter int OFFSET_WIDTH = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// config write channel
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [31:0]                cfg_data,
	// byte stream in
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [7:0]                 s_tdata,  // [7:0] data_byte
	input  wire logic                       s_tlast,  // end_of_buffer
	// result out
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [71:0]                     m_tdata   // [1:0] status, [33:2] box_offset,
	                                                  // [65:34] hit_size, [71:66] zero
);

	cfg_t    cfg_q;
	logic    valid_s1, last_s1;
	logic [7:0] byte_s1;
	logic    out_valid_q;
	result_t out_q;
	logic    walk_emit, advance;
	result_t walk_result;

	// config registers: always ready, indexes past the list are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CONTAINER_START:    cfg_q.container_start    <= cfg_data;
				REG_CONTAINER_LENGTH:   cfg_q.container_length   <= cfg_data;
				REG_CHILD_START_OFFSET: cfg_q.child_start_offset <= cfg_data;
				REG_WANTED_TYPE:        cfg_q.wanted_type        <= cfg_data;
				REG_BUFFER_LENGTH:      cfg_q.buffer_length      <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance the held byte unless it would give a result and the result
	// register is still occupied
	assign advance  = valid_s1 && (!walk_emit || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	mbcf_walk #(
		.OFFSET_WIDTH(OFFSET_WIDTH)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item_valid(valid_s1),
		.data_byte (byte_s1),
		.last      (last_s1),
		.advance   (advance),
		.emit      (walk_emit),
		.result    (walk_result)
	);

	// result register: load on a deciding byte, hold until the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && walk_emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && walk_emit) begin
			out_q <= walk_result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_q};

	// a deciding byte always lands in the result register
	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance && walk_emit |=> m_tvalid)
		else $error("result lost after deciding byte");

	// a found box has a legal size
	a_found_size: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == ST_FOUND) |-> (m_tdata[65:34] >= 32'(HEADER_BYTES)))
		else $error("found box with size below header length");

	// non-found statuses carry zero offset and size
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] != ST_FOUND) |-> (m_tdata[65:2] == 64'd0))
		else $error("status result with nonzero offset or size");

	// an empty input stage never back-pressures the sender
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled while empty");

endmodule

`default_nettype wire

>>> tb/sv/media_box_chain_checker.sv
// Scoreboard for the media box chain finder: mirrors the config registers,
// predicts one result per buffer byte by byte and checks each result transfer.
// Depends on mbcf_pkg.
`default_nettype none

module media_box_chain_checker
	import mbcf_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_valid,
	input  wire logic                       cfg_ready,
	input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [31:0]                cfg_data,
	input  wire logic                       s_tvalid,
	input  wire logic                       s_tready,
	input  wire logic [7:0]                 s_tdata,   // [7:0] data_byte
	input  wire logic                       s_tlast,   // end_of_buffer
	input  wire logic                       m_tvalid,
	input  wire logic                       m_tready,
	input  wire logic [71:0]                m_tdata,   // [1:0] status, [33:2] box_offset,
	                                                   // [65:34] hit_size, [71:66] zero
	output int unsigned                     miss_count,
	output int unsigned                     results_due
);

	localparam int unsigned SHOWN_MISSES = 10;

	cfg_t        regs;
	logic [31:0] byte_pos;
	logic [31:0] box_at;
	logic [63:0] header;
	logic [3:0]  header_len;
	logic        decided;
	result_t     due_results[$];
	int unsigned misses;

	function automatic void restart_walk();
		byte_pos   = '0;
		box_at     = '0;
		header     = '0;
		header_len = '0;
		decided    = 1'b0;
	endfunction

	// Container end, or the buffer length when that is smaller or the end wraps.
	function automatic logic [31:0] walk_limit();
		logic [31:0] cont_end;
		cont_end = regs.container_start + regs.container_length;
		if (cont_end < regs.container_start)
			cont_end = regs.buffer_length;
		return (cont_end < regs.buffer_length) ? cont_end : regs.buffer_length;
	endfunction

	function automatic bit header_spills(input logic [31:0] at, input logic [31:0] limit);
		logic [31:0] past;
		past = at + HEADER_BYTES;
		return (past < at) || (past > limit);
	endfunction

	function automatic void conclude(input status_t st, input logic [31:0] off,
			input logic [31:0] box_len);
		result_t r;
		r.status     = st;
		r.box_offset = off;
		r.hit_size   = box_len;
		due_results.push_back(r);
		decided = 1'b1;
	endfunction

	function automatic void walk_byte(input logic [7:0] data, input logic last);
		logic [31:0] limit;
		logic [31:0] first;
		logic [31:0] box_len;
		logic [31:0] box_end;
		limit = walk_limit();
		if (!decided && byte_pos == '0) begin
			first      = regs.container_start + regs.child_start_offset;
			box_at     = first;
			header     = '0;
			header_len = '0;
			if (first < regs.container_start)
				conclude(ST_BAD_START, '0, '0);
			else if (header_spills(first, limit))
				conclude(ST_NO_ROOM, '0, '0);
		end
		if (!decided && header_len < HEADER_BYTES && byte_pos == box_at + header_len) begin
			header = {header[55:0], data};
			header_len++;
			if (header_len == HEADER_BYTES) begin
				box_len = header[63:32];
				box_end = box_at + box_len;
				if (box_len < HEADER_BYTES || box_end < box_at || box_end > limit)
					conclude(ST_MALFORMED, '0, '0);
				else if (header[31:0] == regs.wanted_type)
					conclude(ST_FOUND, box_at, box_len);
				else begin
					// hop to the next sibling
					box_at     = box_end;
					header     = '0;
					header_len = '0;
					if (header_spills(box_end, limit))
						conclude(ST_NO_ROOM, '0, '0);
				end
			end
		end
		if (byte_pos != '1)
			byte_pos++;
		if (last) begin
			if (!decided)
				conclude(ST_NO_ROOM, '0, '0);
			restart_walk();
		end
	endfunction

	function automatic void log_miss(input string what, input result_t want,
			input result_t got, input logic [5:0] pad);
		misses++;
		if (misses <= SHOWN_MISSES)
			$display("[%0t] %s: expected status %0d offset %h size %h,", $time, what,
				want.status, want.box_offset, want.hit_size,
				" got status %0d offset %h size %h pad %h",
				got.status, got.box_offset, got.hit_size, pad);
	endfunction

	function automatic void check_result(input logic [71:0] word);
		result_t got;
		result_t want;
		got = result_t'(word[65:0]);
		if (due_results.size() == 0) begin
			log_miss("result with nothing due", '0, got, word[71:66]);
			return;
		end
		want = due_results.pop_front();
		if (got.status !== want.status || got.box_offset !== want.box_offset ||
				got.hit_size !== want.hit_size || word[71:66] !== '0)
			log_miss("result mismatch", want, got, word[71:66]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '0;
			restart_walk();
			due_results.delete();
			misses = 0;
			miss_count  <= 0;
			results_due <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CONTAINER_START:    regs.container_start    = cfg_data;
					REG_CONTAINER_LENGTH:   regs.container_length   = cfg_data;
					REG_CHILD_START_OFFSET: regs.child_start_offset = cfg_data;
					REG_WANTED_TYPE:        regs.wanted_type        = cfg_data;
					REG_BUFFER_LENGTH:      regs.buffer_length      = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				walk_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			miss_count  <= misses;
			results_due <= due_results.size();
		end
	end

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Testbench top for the media box chain finder: clock, reset, config and byte
// stimulus, result back-pressure and the verdict.
// Depends on mbcf_pkg, media_box_chain_finder and media_box_chain_checker.
`default_nettype none

module tb_top;
	import mbcf_pkg::*;

	localparam int unsigned ITEM_TARGET    = 1600;
	localparam int unsigned IDLE_PERCENT   = 17;
	localparam int unsigned LONG_HOLD      = 300;
	localparam int unsigned SETTLE_CYCLES  = 4;
	localparam int unsigned CYCLE_LIMIT    = 400000;
	localparam int unsigned REG_COUNT      = 5;
	localparam int unsigned PRESSURE_PHASE = 6;
	localparam int unsigned QUIET_FIRST    = 12;
	localparam int unsigned QUIET_LAST     = 22;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [31:0]                cfg_data;
	logic                       s_tvalid;
	logic                       s_tready;
	logic [7:0]                 s_tdata;
	logic                       s_tlast;
	logic                       m_tvalid;
	logic                       m_tready;
	logic [71:0]                m_tdata;
	int unsigned                miss_count;
	int unsigned                results_due;

	bit          no_gaps;      // both sides stream without idle cycles
	bit          hold_req;     // ask the receiver for one long hold-off
	int unsigned bytes_sent;
	int unsigned cycle_count = 0;
	logic [7:0]  buf_bytes[$]; // current buffer image, offset zero first
	logic [31:0] p_cs, p_cl, p_co, p_want, p_bl;

	media_box_chain_finder u_dut (.*);

	media_box_chain_checker u_checker (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog: a hung handshake or a missing result ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("media_box_chain_finder verification failed");
			$finish;
		end
	end

	// Result receiver: random stalls, a quiet stretch, and one long hold-off
	// that is counted here so the block backs up into its input stage.
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		m_tready  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (no_gaps)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
		end
	end

	// Leave cfg_valid high; the caller drops it after the last write.
	task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] index, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Offer one byte, with random idle cycles ahead of it, and hold it until
	// the transfer completes. Leave s_tvalid high for the next byte.
	task automatic send_byte(input logic [7:0] data, input logic last);
		while (!no_gaps && $urandom_range(0, 99) < IDLE_PERCENT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	// Program all five registers, stream the buffer image one or more times
	// back to back, then drain: every result in, plus the input stage tail.
	task automatic run_phase(input logic [31:0] cs, input logic [31:0] cl,
			input logic [31:0] co, input logic [31:0] want, input logic [31:0] bl,
			input int unsigned copies);
		int unsigned c;
		int unsigned i;
		write_reg(REG_CONTAINER_START, cs);
		write_reg(REG_CONTAINER_LENGTH, cl);
		write_reg(REG_CHILD_START_OFFSET, co);
		write_reg(REG_WANTED_TYPE, want);
		write_reg(REG_BUFFER_LENGTH, bl);
		cfg_valid <= 1'b0;
		for (c = 0; c < copies; c++)
			for (i = 0; i < buf_bytes.size(); i++)
				send_byte(buf_bytes[i], i == buf_bytes.size() - 1);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_fourcc();
		case ($urandom_range(0, 7))
			0: return "moov";
			1: return "trak";
			2: return "mdia";
			3: return "minf";
			4: return "stbl";
			5: return "free";
			default: return $urandom();
		endcase
	endfunction

	// Lay out a buffer: filler up to the first child, a chain of boxes with
	// random payload, then trailing bytes. Most chains are well formed; the
	// rest get a short or oversized box, a skewed container or buffer
	// length, a wrapping start offset, or an early end of buffer.
	task automatic plan_random_buffer();
		int unsigned lead, nboxes, bad_box, b, k, body, roll, chain_end, cut;
		logic [31:0] ty, hdr_size;
		buf_bytes.delete();
		p_want = pick_fourcc();
		p_cs   = $urandom_range(0, 6);
		p_co   = $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(0, 12));
		lead   = p_cs + p_co;
		for (k = 0; k < lead; k++)
			buf_bytes.push_back(8'($urandom()));
		nboxes  = $urandom_range(1, 4);
		bad_box = $urandom_range(0, nboxes - 1);
		roll    = $urandom_range(0, 99);
		for (b = 0; b < nboxes; b++) begin
			body     = $urandom_range(0, 1) ? 0 : $urandom_range(1, 10);
			hdr_size = HEADER_BYTES + body;
			if (b == bad_box && roll < 10)
				hdr_size = $urandom_range(0, HEADER_BYTES - 1);
			else if (b == bad_box && roll < 16)
				hdr_size = $urandom_range(32'hFFFF_FFFF, 32'hFFFF_FFF0);
			else if (b == bad_box && roll < 20)
				hdr_size = hdr_size + $urandom_range(1, 40);
			k = $urandom_range(0, 99);
			if (k < 35)
				ty = p_want;
			else if (k < 60)
				ty = p_want ^ (32'd1 << $urandom_range(0, 31));  // near miss
			else
				ty = pick_fourcc();
			for (k = 0; k < 4; k++)
				buf_bytes.push_back(hdr_size[31 - 8*k -: 8]);
			for (k = 0; k < 4; k++)
				buf_bytes.push_back(ty[31 - 8*k -: 8]);
			for (k = 0; k < body; k++)
				buf_bytes.push_back(8'($urandom()));
		end
		chain_end = buf_bytes.size();
		repeat ($urandom_range(0, 4)) buf_bytes.push_back(8'($urandom()));

		roll = $urandom_range(0, 99);
		if (roll < 55)
			p_cl = chain_end - p_cs;
		else if (roll < 65)
			p_cl = chain_end - p_cs - $urandom_range(1, 8);
		else if (roll < 78)
			p_cl = chain_end - p_cs + $urandom_range(1, 20);
		else if (roll < 90)
			p_cl = 32'hFFFF_FFFF - $urandom_range(0, 3);
		else
			p_cl = $urandom();

		roll = $urandom_range(0, 99);
		if (roll < 72)
			p_bl = buf_bytes.size();
		else if (roll < 82)
			p_bl = buf_bytes.size() - $urandom_range(1, 6);
		else if (roll < 90)
			p_bl = 32'hFFFF_FFFF;
		else
			p_bl = $urandom_range(0, buf_bytes.size() + 10);

		// Cut the tail after the length was fixed so the buffer ends early.
		if ($urandom_range(0, 99) < 10) begin
			cut = $urandom_range(1, (buf_bytes.size() > 12) ? 12 : buf_bytes.size() - 1);
			repeat (cut) void'(buf_bytes.pop_back());
		end

		roll = $urandom_range(0, 99);
		if (roll < 6) begin
			p_cs = 32'hFFFF_FFFF - $urandom_range(0, 3);
			p_co = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'($urandom_range(4, 32'hFFFF));
		end else if (roll < 9) begin
			p_cs = '0;
			p_co = 32'hFFFF_FFFF;
		end
	endtask

	initial begin
		int unsigned k;
		int unsigned phase;
		int unsigned copies;
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tlast    = 1'b0;
		no_gaps    = 1'b0;
		hold_req   = 1'b0;
		bytes_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Writes to unused register indexes must change nothing.
		for (k = REG_COUNT; k < (1 << CFG_INDEX_WIDTH); k++)
			write_reg(CFG_INDEX_WIDTH'(k), $urandom());

		// Start offset wraps: bad start on the first byte.
		buf_bytes = '{8'hFF};
		run_phase(32'hFFFF_FFFF, 32'h0, 32'h1, 32'h0, 32'hFFFF_FFFF, 1);
		// Zero buffer length: no room for the first header; the next byte is dropped.
		buf_bytes = '{8'h00, 8'hA5};
		run_phase(32'h0, 32'h10, 32'h0, "moov", 32'h0, 1);
		// Smallest box that matches, at offset zero, all-ones type.
		buf_bytes = '{8'h00, 8'h00, 8'h00, 8'h08, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		run_phase(32'h0, 32'h8, 32'h0, 32'hFFFF_FFFF, 32'h8, 1);
		// Size below the header length: malformed, then trailing bytes ignored.
		buf_bytes = '{8'h00, 8'h00, 8'h00, 8'h07, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h11, 8'h22};
		run_phase(32'h0, 32'h100, 32'h0, 32'h0, 32'd10, 1);
		// Buffer ends before the first header completes.
		buf_bytes = '{8'h00, 8'h00, 8'h01};
		run_phase(32'h0, 32'd64, 32'h0, "trak", 32'd64, 1);
		// Container end wraps: the buffer length bounds the walk.
		buf_bytes = '{8'h5A, 8'h00, 8'h00, 8'h00, 8'h08, 8'h74, 8'h72, 8'h61, 8'h6B};
		run_phase(32'h1, 32'hFFFF_FFFF, 32'h0, "trak", 32'd9, 1);

		phase = 0;
		while (bytes_sent < ITEM_TARGET) begin
			plan_random_buffer();
			no_gaps = (phase >= QUIET_FIRST && phase < QUIET_LAST);
			copies  = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
			if (phase == PRESSURE_PHASE) begin
				// Several buffers against a stalled receiver fill the block.
				hold_req = 1'b1;
				copies   = 4;
			end
			run_phase(p_cs, p_cl, p_co, p_want, p_bl, copies);
			phase++;
		end

		if (miss_count == 0 && results_due == 0)
			$display("media_box_chain_finder verification clean");
		else
			$display("media_box_chain_finder verification failed");
		$finish;
	end

endmodule

`default_nettype wire
